>>> design/mss_pkg.sv
// package for the microcoded state sequencer
// holds sizes, microcode word field positions, command codes and the result type
// no dependencies
package mss_pkg;

  localparam int STATE_COUNT = 8;
  localparam int VAR_COUNT   = 8;
  localparam int CODE_DEPTH  = 256;
  localparam int JUMP_BITS   = 8;
  localparam int SELECT_BITS = 3;
  localparam int STACK_DEPTH = 16;
  localparam int SKIP_BITS   = 6;

  localparam int WORD_W      = 47;
  localparam int BYTE_W      = 8;
  localparam int PC_W        = 8;
  localparam int CODE_ADDR_W = $clog2(CODE_DEPTH);
  localparam int VAR_IDX_W   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = 5;

  // microcode word layout, from bit 0
  localparam int VAL_LSB    = 0;
  localparam int MASK_LSB   = VAL_LSB + STATE_COUNT;
  localparam int JUMP_LSB   = MASK_LSB + STATE_COUNT;
  localparam int SEL_LSB    = JUMP_LSB + JUMP_BITS;
  localparam int CAP_POS    = SEL_LSB + SELECT_BITS + SKIP_BITS;
  localparam int BRANCH_POS = CAP_POS + 2;
  localparam int FORCED_POS = BRANCH_POS + 1;
  localparam int CALL_POS   = FORCED_POS + 1;
  localparam int RET_POS    = CALL_POS + 1;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_VAR_WR  = 2'd1,
    CMD_CODE_WR = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // packed so that state_bits lands in the lowest bits
  typedef struct packed {
    logic               ready_res;
    logic               fired;
    logic [DEPTH_W-1:0] stack_depth;
    logic [PC_W-1:0]    address;
    logic [BYTE_W-1:0]  state_bits;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

>>> design/mss_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// used for the microcode store; no package dependencies
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> design/microcoded_state_sequencer.sv
// top level of the microcoded state sequencer
// depends on mss_pkg and mss_ram (microcode store)
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid_i/s_axis_tready_o| tuser: cmd; tdata: index, var_value,
//            |     |                                |        code_word
//  m_axis    | out | m_axis_tvalid_o/m_axis_tready_i| tdata: state_bits, address,
//            |     |                                |        stack_depth, fired, ready_res
//
// one item per cycle while tready is high: every item is finished in the cycle it is
// accepted and its result is registered. the microcode ram is read every cycle at the
// next program address, fed straight from the next-address logic, so the word for the
// next execute waits in the ram read register. a write to the word being prefetched is
// forwarded. reset clears the flags, address, stack count and variables at once; no
// clearing pass. an output register plus a skid stage let the input side keep going while
// one result waits; tready drops only when both are full.
module microcoded_state_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // cmd [1:0]
  input  logic [1:0]                      s_axis_tuser_i,
  // index [7:0], var_value [15:8], code_word [62:16], zero [63]
  input  logic [mss_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // state_bits [7:0], address [15:8], stack_depth [20:16], fired [21],
  // ready_res [22], zero [23]
  output logic [mss_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import mss_pkg::*;

  // unpacked input item
  cmd_e              cmd;
  logic [BYTE_W-1:0] in_index;
  logic [BYTE_W-1:0] in_var_value;
  logic [WORD_W-1:0] in_code_word;
  logic              accept;

  assign cmd          = cmd_e'(s_axis_tuser_i);
  assign in_index     = s_axis_tdata_i[BYTE_W-1:0];
  assign in_var_value = s_axis_tdata_i[2*BYTE_W-1:BYTE_W];
  assign in_code_word = s_axis_tdata_i[2*BYTE_W+WORD_W-1:2*BYTE_W];
  assign accept       = s_axis_tvalid_i && s_axis_tready_o;

  // architectural state
  logic [STATE_COUNT-1:0] flags_q, flags_d;
  logic [PC_W-1:0]        pc_q, pc_d;
  logic [DEPTH_W-1:0]     count_q, count_d;
  logic                   fired_q, fired_d;
  logic                   ready_q, ready_d;
  logic [BYTE_W-1:0]      var_q [VAR_COUNT];
  logic [PC_W-1:0]        stack_q [STACK_DEPTH];

  // microcode store and write forwarding
  logic                   code_wr_en;
  logic [CODE_ADDR_W-1:0] code_wr_addr;
  logic [CODE_ADDR_W-1:0] code_rd_addr;
  logic [WORD_W-1:0]      code_rd_data;
  logic                   fwd_hit_q;
  logic [WORD_W-1:0]      fwd_word_q;
  logic [WORD_W-1:0]      word;

  assign code_wr_en   = accept && (cmd == CMD_CODE_WR) &&
                        ({1'b0, in_index} < (BYTE_W+1)'(CODE_DEPTH));
  assign code_wr_addr = in_index[CODE_ADDR_W-1:0];
  assign code_rd_addr = pc_d[CODE_ADDR_W-1:0];

  mss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CODE_DEPTH)
  ) u_code_ram (
    .clk_i     (clk_i),
    .wr_en_i   (code_wr_en),
    .wr_addr_i (code_wr_addr),
    .wr_data_i (in_code_word),
    .rd_addr_i (code_rd_addr),
    .rd_data_o (code_rd_data)
  );

  // the ram returns old data when it is written at the address being read
  assign word = fwd_hit_q ? fwd_word_q : code_rd_data;

  // microcode word fields
  logic [STATE_COUNT-1:0] w_values;
  logic [STATE_COUNT-1:0] w_mask;
  logic [JUMP_BITS-1:0]   w_jump;
  logic [SELECT_BITS-1:0] w_sel;
  logic                   w_capture, w_branch, w_forced, w_call, w_ret;

  assign w_values  = word[VAL_LSB  +: STATE_COUNT];
  assign w_mask    = word[MASK_LSB +: STATE_COUNT];
  assign w_jump    = word[JUMP_LSB +: JUMP_BITS];
  assign w_sel     = word[SEL_LSB  +: SELECT_BITS];
  assign w_capture = word[CAP_POS];
  assign w_branch  = word[BRANCH_POS];
  assign w_forced  = word[FORCED_POS];
  assign w_call    = word[CALL_POS];
  assign w_ret     = word[RET_POS];

  // execute step
  logic               cond;
  logic               fire;
  logic               do_pop;
  logic [DEPTH_W-1:0] count_pop;
  logic [DEPTH_W-1:0] count_pop_m1;
  logic               do_push;
  logic [PC_W:0]      next_wide;
  logic [PC_W-1:0]    ret_addr;
  logic               var_wr_en;

  assign ret_addr     = pc_q + PC_W'(1);
  assign count_pop_m1 = count_q - DEPTH_W'(1);
  assign var_wr_en    = accept && (cmd == CMD_VAR_WR) &&
                        ({1'b0, in_index} < (BYTE_W+1)'(VAR_COUNT));

  always_comb begin
    // a select past the variables counts as true
    cond = 1'b1;
    if ({1'b0, w_sel} < (SELECT_BITS+1)'(VAR_COUNT)) begin
      cond = (var_q[w_sel[VAR_IDX_W-1:0]] != '0);
    end
    fire   = (cond && w_branch) || w_forced || w_ret;
    do_pop = fire && w_ret && (count_q != '0);
    count_pop = do_pop ? count_pop_m1 : count_q;

    if (do_pop) begin
      next_wide = {1'b0, stack_q[count_pop_m1[STK_IDX_W-1:0]]};
    end else if (fire) begin
      next_wide = (PC_W+1)'(w_jump);
    end else begin
      next_wide = {1'b0, pc_q} + (PC_W+1)'(1);
    end
    // addresses wrap at the store size
    if (next_wide >= (PC_W+1)'(CODE_DEPTH)) begin
      next_wide = '0;
    end

    // a call on a full stack is dropped
    do_push = w_call && (count_pop < DEPTH_W'(STACK_DEPTH));

    flags_d = flags_q;
    pc_d    = pc_q;
    count_d = count_q;
    fired_d = fired_q;
    ready_d = ready_q;
    if (accept && (cmd == CMD_EXEC)) begin
      if (w_capture) begin
        flags_d = (flags_q & ~w_mask) | (w_values & w_mask);
      end
      pc_d    = next_wide[PC_W-1:0];
      count_d = do_push ? count_pop + DEPTH_W'(1) : count_pop;
      fired_d = fire;
      ready_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      pc_q    <= '0;
      count_q <= '0;
      fired_q <= 1'b0;
      ready_q <= 1'b0;
      for (int i = 0; i < VAR_COUNT; i++) begin
        var_q[i] <= '0;
      end
      fwd_hit_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      pc_q    <= pc_d;
      count_q <= count_d;
      fired_q <= fired_d;
      ready_q <= ready_d;
      if (var_wr_en) begin
        var_q[in_index[VAR_IDX_W-1:0]] <= in_var_value;
      end
      fwd_hit_q <= code_wr_en && (code_wr_addr == code_rd_addr);
    end
  end

  // return stack and forwarded word: payload only
  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_EXEC) && do_push) begin
      stack_q[count_pop[STK_IDX_W-1:0]] <= ret_addr;
    end
    fwd_word_q <= in_code_word;
  end

  // result of the accepted item: state after the command
  result_t res_new;

  always_comb begin
    res_new.state_bits  = BYTE_W'(flags_d);
    res_new.address     = pc_d;
    res_new.stack_depth = count_d;
    res_new.fired       = fired_d;
    res_new.ready_res   = ready_d;
  end

  // output register plus skid stage
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_pop;

  assign out_pop         = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W-RESULT_W)'(0), out_q};

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (accept) begin
      if (!out_valid_q || out_pop) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_new;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule
